>>> hdl/cwc_pkg.sv
// Package for the congestion window controller.
// Holds port widths, register indexes and the window and arithmetic constants.
// No dependencies.
package cwc_pkg;

    // Field and port widths
    localparam int WIN_W      = 16;
    localparam int TMO_W      = 17;
    localparam int TS_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 96;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 40;

    // Tick arithmetic widths: numerator, divisor, multiplier operand
    localparam int NUM_W  = 51;
    localparam int DEN_W  = 35;
    localparam int MULB_W = 19;
    localparam int QCNT_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_AIMD          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_DELAY_TRIGGER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_DELAY_BASED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_THRESHOLD_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS              = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MIN_RTT      = 3'd6;

    // Register reset values
    localparam logic [WIN_W-1:0] RST_INITIAL_WINDOW  = 16'd20;
    localparam logic [WIN_W-1:0] RST_DELAY_THRESHOLD = 16'd450;
    localparam logic [WIN_W-1:0] RST_TICK_MS         = 16'd20;
    localparam logic [WIN_W-1:0] RST_INITIAL_MIN_RTT = 16'd50;

    // Window rules
    localparam logic [WIN_W-1:0] WIN_MAX  = 16'hFFFF;
    localparam logic [WIN_W-1:0] DT_DEC   = 16'd10;
    localparam logic [16:0]      AI_STEP  = 17'd2;
    localparam logic [16:0]      DT_INC   = 17'd1;
    localparam logic [TS_W-1:0]  ACK_MAX  = 32'hFFFF_FFFF;

    // Event kind carried in s_tuser[0]
    localparam logic MODE_ACK  = 1'b0;
    localparam logic MODE_SENT = 1'b1;

endpackage

>>> hdl/congestion_window_controller_core.sv
// Congestion window controller: AIMD, delay-triggered and delay-based window rules.
// Uses cwc_pkg; one multiplier and one wide subtractor shared under a sequencer.
//
// One event word is taken at a time; s_tready is low until its result is
// registered for output, while a previous result may still wait on m_tready.
// A send event goes through the halving step alone. An ack without a tick
// update goes through the AIMD, delay-triggered, min RTT and growth test steps
// (no growth test with the delay-based mode off). An ack that starts a new tick
// also takes two passes through the shared 32x19 multiplier, one add, a
// saturation test and 16 restoring division steps through the shared 51-bit
// subtractor, one quotient bit each; a tick whose result saturates skips the division.
// A result held by m_tready stalls the sequencer in its done state, and the next
// word can be taken in the cycle after the result is registered.
// Writing initial_window or initial_min_rtt also loads the live window or
// minimum RTT.
module congestion_window_controller_core
    import cwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Event channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // acked_sequence[31:0], acked_send_time[63:32], ack_arrival_time[95:64]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // mode[0], sent_after_timeout[1]
    input  logic [S_USER_W-1:0]   s_tuser,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // window[15:0], timeout_value[32:16], zero fill[39:33]
    output logic [M_DATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEND, S_AIMD, S_DTRIG, S_DB1, S_DB2,
        S_MUL1, S_MUL2, S_ADD, S_SAT, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic             en_aimd_reg, en_dtrig_reg, en_dbased_reg;
    logic [WIN_W-1:0] thresh_reg, tick_reg;

    // Controller state
    logic [WIN_W-1:0] cwnd_reg;
    logic [16:0]      progress_reg;
    logic [TS_W-1:0]  highest_reg;
    logic [WIN_W-1:0] min_rtt_reg;
    logic [TS_W-1:0]  tick_start_reg;
    logic [TS_W-1:0]  acks_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Event payload and working registers
    logic              after_to_reg;
    logic [TS_W-1:0]   seq_reg, arr_reg, rtt_reg, elapsed_reg;
    logic [NUM_W-1:0]  prod_reg, num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  div_reg;
    logic [WIN_W-1:0]  quo_reg;
    logic [QCNT_W-1:0] cnt_reg;

    // Combinational helpers
    logic [WIN_W-1:0]  cwnd_inc;
    logic [16:0]       prog_next;
    logic              prog_hit;
    logic [TS_W-1:0]   elapsed_next;
    logic              tick_due;
    logic [32:0]       rtt_x2;
    logic [32:0]       min_x3;
    logic [TS_W-1:0]   mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [NUM_W-1:0]  mul_p;
    logic [NUM_W-1:0]  sub_b;
    logic [NUM_W:0]    sub_diff;
    logic              sub_borrow;
    logic [WIN_W-1:0]  quo_next;
    logic              out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Result register takes a new word when empty or being drained
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Saturating window growth by one
    assign cwnd_inc = (cwnd_reg != WIN_MAX) ? cwnd_reg + 16'd1 : cwnd_reg;

    // Progress count step: add 2 in the AIMD step, 1 in the delay-triggered step
    assign prog_next = progress_reg + ((state_reg == S_AIMD) ? AI_STEP : DT_INC);
    assign prog_hit  = (prog_next >= {1'b0, cwnd_reg});

    // Tick timing and the 1.5 x min RTT growth test
    assign elapsed_next = arr_reg - tick_start_reg;
    assign tick_due     = (elapsed_next >= {16'd0, tick_reg}) && (elapsed_next != '0);
    assign rtt_x2       = {rtt_reg, 1'b0};
    assign min_x3       = 33'({min_rtt_reg, 1'b0}) + 33'(min_rtt_reg);

    // Shared multiplier: min RTT x acks, then elapsed x (5 + 4 x window)
    always_comb begin
        if (state_reg == S_MUL1) begin
            mul_a = acks_reg;
            mul_b = MULB_W'(min_rtt_reg);
        end else begin
            mul_a = elapsed_reg;
            mul_b = {1'b0, cwnd_reg, 2'b00} + 19'd5;
        end
    end
    assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);

    // Shared subtractor: saturation test, then one quotient bit per step
    assign sub_b      = (state_reg == S_SAT) ? {den_reg, 16'd0} : div_reg;
    assign sub_diff   = {1'b0, num_reg} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[NUM_W];
    assign quo_next   = {quo_reg[WIN_W-2:0], ~sub_borrow};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            en_aimd_reg    <= 1'b0;
            en_dtrig_reg   <= 1'b0;
            en_dbased_reg  <= 1'b1;
            thresh_reg     <= RST_DELAY_THRESHOLD;
            tick_reg       <= RST_TICK_MS;
            cwnd_reg       <= RST_INITIAL_WINDOW;
            progress_reg   <= '0;
            highest_reg    <= '0;
            min_rtt_reg    <= RST_INITIAL_MIN_RTT;
            tick_start_reg <= '0;
            acks_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Load a new result, or drop the old one once taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                // Capture the event word
                S_IDLE: begin
                    if (s_tvalid) begin
                        after_to_reg <= s_tuser[1];
                        seq_reg      <= s_tdata[31:0];
                        arr_reg      <= s_tdata[95:64];
                        rtt_reg      <= s_tdata[95:64] - s_tdata[63:32];
                        state_reg    <= (s_tuser[0] == MODE_SENT) ? S_SEND : S_AIMD;
                    end
                end
                // Halve on a timeout send
                S_SEND: begin
                    if (en_aimd_reg && after_to_reg) begin
                        cwnd_reg <= {1'b0, cwnd_reg[WIN_W-1:1]};
                    end
                    state_reg <= S_DONE;
                end
                // Additive increase
                S_AIMD: begin
                    if (en_aimd_reg) begin
                        if (prog_hit) begin
                            cwnd_reg     <= cwnd_inc;
                            progress_reg <= '0;
                        end else begin
                            progress_reg <= prog_next;
                        end
                    end
                    state_reg <= S_DTRIG;
                end
                // Delay-triggered grow or cut, then track highest ack
                S_DTRIG: begin
                    if (en_dtrig_reg) begin
                        if (rtt_reg < {16'd0, thresh_reg} && seq_reg > highest_reg) begin
                            if (prog_hit) begin
                                cwnd_reg     <= cwnd_inc;
                                progress_reg <= '0;
                            end else begin
                                progress_reg <= prog_next;
                            end
                        end else begin
                            cwnd_reg <= (cwnd_reg >= DT_DEC) ? cwnd_reg - DT_DEC : '0;
                        end
                    end
                    if (seq_reg > highest_reg) begin
                        highest_reg <= seq_reg;
                    end
                    state_reg <= S_DB1;
                end
                // Count the ack and track minimum RTT
                S_DB1: begin
                    if (en_dbased_reg) begin
                        if (acks_reg != ACK_MAX) begin
                            acks_reg <= acks_reg + 32'd1;
                        end
                        if (rtt_reg < {16'd0, min_rtt_reg}) begin
                            min_rtt_reg <= rtt_reg[WIN_W-1:0];
                        end
                        state_reg <= S_DB2;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                // Grow on low RTT, decide on a tick update
                S_DB2: begin
                    if (rtt_x2 <= min_x3) begin
                        cwnd_reg <= cwnd_inc;
                    end
                    elapsed_reg <= elapsed_next;
                    state_reg   <= tick_due ? S_MUL1 : S_DONE;
                end
                S_MUL1: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    num_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_ADD;
                end
                // Form numerator and 5 x elapsed
                S_ADD: begin
                    num_reg   <= num_reg + prod_reg;
                    den_reg   <= {1'b0, elapsed_reg, 2'b00} + DEN_W'(elapsed_reg);
                    state_reg <= S_SAT;
                end
                // Saturate when the quotient exceeds 16 bits
                S_SAT: begin
                    if (!sub_borrow) begin
                        cwnd_reg       <= WIN_MAX;
                        acks_reg       <= '0;
                        tick_start_reg <= arr_reg;
                        state_reg      <= S_DONE;
                    end else begin
                        div_reg   <= {1'b0, den_reg, 15'd0};
                        quo_reg   <= '0;
                        cnt_reg   <= QCNT_W'(WIN_W - 1);
                        state_reg <= S_DIV;
                    end
                end
                // Restoring division, one quotient bit per cycle
                S_DIV: begin
                    if (!sub_borrow) begin
                        num_reg <= sub_diff[NUM_W-1:0];
                    end
                    quo_reg <= quo_next;
                    div_reg <= {1'b0, div_reg[NUM_W-1:1]};
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0) begin
                        cwnd_reg       <= quo_next;
                        acks_reg       <= '0;
                        tick_start_reg <= arr_reg;
                        state_reg      <= S_DONE;
                    end
                end
                // Hand the result to the output register
                S_DONE: begin
                    if (out_load) begin
                        m_tdata_reg <= {7'd0, min_rtt_reg, 1'b0, cwnd_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes, with live loads of window and minimum RTT
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENABLE_AIMD:          en_aimd_reg   <= cfg_wdata[0];
                    REG_ENABLE_DELAY_TRIGGER: en_dtrig_reg  <= cfg_wdata[0];
                    REG_ENABLE_DELAY_BASED:   en_dbased_reg <= cfg_wdata[0];
                    REG_INITIAL_WINDOW:       cwnd_reg      <= cfg_wdata;
                    REG_DELAY_THRESHOLD_MS:   thresh_reg    <= cfg_wdata;
                    REG_TICK_MS:              tick_reg      <= cfg_wdata;
                    REG_INITIAL_MIN_RTT:      min_rtt_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hdl/cwc_checker.sv
// Port-level checker for the congestion window controller, bound to the top level.
// Uses cwc_pkg for port widths.
module cwc_checker
    import cwc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One event word at a time: busy right after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second word while busy");

    // Timeout is twice the minimum RTT, so always even
    a_tmo_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[16])
        else $error("odd timeout value");

    // Zero fill above the result fields
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("nonzero fill in result word");

endmodule

bind congestion_window_controller_core cwc_checker u_cwc_checker (.*);

>>> tb/congestion_window_controller_core_tb.sv
// Self-checking testbench for congestion_window_controller_core.
// Predicts window and timeout for every event word and checks each result word.
// Depends on cwc_pkg and the core RTL only.
module congestion_window_controller_core_tb;
    import cwc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 212;

    typedef struct packed {
        logic        mode;
        logic        timeout_flag;
        logic [31:0] seq;
        logic [31:0] sent_ms;
        logic [31:0] arrival_ms;
    } cwc_event_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [TMO_W-1:0] timeout;
    } window_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predicted controller state and configuration
    logic        en_aimd, en_dtrig, en_dbased;
    logic [15:0] threshold_r, tick_r;
    logic [15:0] exp_window, exp_min_rtt;
    logic [16:0] exp_progress;
    logic [31:0] exp_top_seq, exp_tick_start, exp_tick_acks;

    window_result_t pending_results[$];

    // Ack stream generator state
    logic [31:0] clock_ms, next_seq;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_left  = 0;
    int n_events    = 0;
    int n_checked   = 0;
    int n_errors    = 0;

    congestion_window_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Saturating +1 on the window
    function automatic void bump_window();
        if (exp_window != WIN_MAX) begin
            exp_window = exp_window + 16'd1;
        end
    endfunction

    // Add to the progress count; grow and clear once it reaches the window
    function automatic void credit_progress(input logic [16:0] amount);
        exp_progress = exp_progress + amount;
        if (exp_progress >= {1'b0, exp_window}) begin
            bump_window();
            exp_progress = '0;
        end
    endfunction

    // Apply one event to the predicted state and return the expected result word
    function automatic window_result_t predict_event(input cwc_event_t ev);
        logic [31:0]    rtt;
        logic [31:0]    elapsed;
        logic [63:0]    num, den, quo;
        window_result_t res;
        if (ev.mode == MODE_SENT) begin
            if (en_aimd && ev.timeout_flag) begin
                exp_window = exp_window >> 1;
            end
        end else begin
            rtt = ev.arrival_ms - ev.sent_ms;
            if (en_aimd) begin
                credit_progress(AI_STEP);
            end
            if (en_dtrig) begin
                if (rtt < {16'd0, threshold_r} && ev.seq > exp_top_seq) begin
                    credit_progress(DT_INC);
                end else begin
                    exp_window = (exp_window >= DT_DEC) ? exp_window - DT_DEC : '0;
                end
            end
            if (ev.seq > exp_top_seq) begin
                exp_top_seq = ev.seq;
            end
            if (en_dbased) begin
                if (exp_tick_acks != ACK_MAX) begin
                    exp_tick_acks = exp_tick_acks + 32'd1;
                end
                if (rtt < {16'd0, exp_min_rtt}) begin
                    exp_min_rtt = rtt[15:0];
                end
                // Growth when rtt is within 1.5x of the minimum
                if ({31'd0, rtt, 1'b0} <= {48'd0, exp_min_rtt} * 64'd3) begin
                    bump_window();
                end
                // Throughput update once per tick
                elapsed = ev.arrival_ms - exp_tick_start;
                if (elapsed >= {16'd0, tick_r} && elapsed != 32'd0) begin
                    num = {48'd0, exp_min_rtt} * {32'd0, exp_tick_acks}
                        + {32'd0, elapsed} * (64'd5 + 64'd4 * {48'd0, exp_window});
                    den = 64'd5 * {32'd0, elapsed};
                    quo = num / den;
                    exp_window = (quo > {48'd0, WIN_MAX}) ? WIN_MAX : quo[15:0];
                    exp_tick_acks = '0;
                    exp_tick_start = ev.arrival_ms;
                end
            end
        end
        res.window = exp_window;
        res.timeout = {exp_min_rtt, 1'b0};
        return res;
    endfunction

    function automatic cwc_event_t make_event(input logic mode, input logic after_to,
                                              input logic [31:0] seq,
                                              input logic [31:0] sent_ms,
                                              input logic [31:0] arrival_ms);
        cwc_event_t ev;
        ev.mode = mode;
        ev.timeout_flag = after_to;
        ev.seq = seq;
        ev.sent_ms = sent_ms;
        ev.arrival_ms = arrival_ms;
        return ev;
    endfunction

    // Next ack of a plausible stream: rising time, mostly fresh sequence numbers,
    // rtt around the minimum, around the threshold or anywhere
    function automatic cwc_event_t make_ack();
        cwc_event_t  ev;
        logic [31:0] rtt;
        if ($urandom_range(19, 0) == 0) begin
            clock_ms = clock_ms + $urandom_range(5000, 0);
        end else begin
            clock_ms = clock_ms + $urandom_range(12, 0);
        end
        case ($urandom_range(3, 0))
            0: rtt = $urandom_range(2 * exp_min_rtt + 2, 0);
            1: rtt = $urandom_range(threshold_r + 20, 0);
            2: rtt = $urandom_range(400, 0);
            default: rtt = $urandom_range(70000, 0);
        endcase
        if ($urandom_range(4, 0) == 0) begin
            ev.seq = next_seq - $urandom_range(4, 0);
        end else begin
            next_seq = next_seq + $urandom_range(3, 1);
            ev.seq = next_seq;
        end
        ev.mode = MODE_ACK;
        ev.timeout_flag = 1'($urandom_range(1, 0));
        ev.arrival_ms = clock_ms;
        ev.sent_ms = clock_ms - rtt;
        return ev;
    endfunction

    // Offer one event word, idle at random first, record its prediction on acceptance
    task automatic send_event(input cwc_event_t ev);
        @(negedge aclk);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = {ev.timeout_flag, ev.mode};
        s_tdata = {ev.arrival_ms, ev.sent_ms, ev.seq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_event(ev));
        n_events++;
    endtask

    // Drop valid and hold until every predicted result has been checked
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Register write while idle, mirrored into the prediction
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            REG_ENABLE_AIMD:          en_aimd = value[0];
            REG_ENABLE_DELAY_TRIGGER: en_dtrig = value[0];
            REG_ENABLE_DELAY_BASED:   en_dbased = value[0];
            REG_INITIAL_WINDOW:       exp_window = value;
            REG_DELAY_THRESHOLD_MS:   threshold_r = value;
            REG_TICK_MS:              tick_r = value;
            REG_INITIAL_MIN_RTT:      exp_min_rtt = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_setting(input logic aimd, input logic dtrig, input logic dbased,
                                 input logic [15:0] win, input logic [15:0] thr,
                                 input logic [15:0] tick, input logic [15:0] min_rtt);
        set_reg(REG_ENABLE_AIMD, {15'd0, aimd});
        set_reg(REG_ENABLE_DELAY_TRIGGER, {15'd0, dtrig});
        set_reg(REG_ENABLE_DELAY_BASED, {15'd0, dbased});
        set_reg(REG_INITIAL_WINDOW, win);
        set_reg(REG_DELAY_THRESHOLD_MS, thr);
        set_reg(REG_TICK_MS, tick);
        set_reg(REG_INITIAL_MIN_RTT, min_rtt);
    endtask

    // Defaults after reset: sends leave the window alone, zero rtt at time zero
    task automatic test_reset_defaults();
        send_event(make_event(MODE_SENT, 1'b1, 32'd0, 32'd0, 32'd0));
        send_event(make_event(MODE_SENT, 1'b0, 32'd0, 32'd0, 32'd0));
        send_event(make_event(MODE_ACK, 1'b0, 32'd0, 32'd0, 32'd0));
    endtask

    // All modes on, registers at their extremes, all-ones fields, wrapped rtt
    task automatic test_field_extremes();
        apply_setting(1'b1, 1'b1, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(make_event(MODE_ACK, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_event(make_event(MODE_ACK, 1'b0, 32'd0, 32'hFFFF_FFF0, 32'h0000_0010));
        send_event(make_event(MODE_SENT, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    endtask

    task automatic test_special_cases();
        // Delay cut from below ten down to zero, then at zero
        apply_setting(1'b0, 1'b1, 1'b0, 16'd7, 16'd0, 16'd20, 16'd50);
        send_event(make_event(MODE_ACK, 1'b0, 32'd5, 32'd100, 32'd200));
        send_event(make_event(MODE_ACK, 1'b0, 32'd6, 32'd100, 32'd200));
        // Growth at the ceiling, then a tick whose result overflows the window
        apply_setting(1'b0, 1'b0, 1'b1, WIN_MAX, 16'd450, 16'd1, 16'hFFFF);
        send_event(make_event(MODE_ACK, 1'b0, 32'd9, 32'd1000 - 32'd65535, 32'd1000));
        set_reg(REG_INITIAL_WINDOW, WIN_MAX);
        send_event(make_event(MODE_ACK, 1'b0, 32'd10, 32'd1001 - 32'd65535, 32'd1001));
        // Zero tick length: no update at zero elapsed time, update one ms later
        set_reg(REG_TICK_MS, 16'd0);
        send_event(make_event(MODE_ACK, 1'b0, 32'd11, 32'd1000, 32'd1001));
        send_event(make_event(MODE_ACK, 1'b0, 32'd12, 32'd1000, 32'd1002));
        // Write to an unmapped index must change nothing
        set_reg(REG_UNMAPPED, 16'hFFFF);
        send_event(make_event(MODE_SENT, 1'b0, 32'd0, 32'd0, 32'd0));
        // AIMD from a zero window, halving, regrowth
        apply_setting(1'b1, 1'b0, 1'b0, 16'd0, 16'd450, 16'd20, 16'd50);
        send_event(make_event(MODE_ACK, 1'b0, 32'd13, 32'd0, 32'd5));
        send_event(make_event(MODE_SENT, 1'b1, 32'd0, 32'd0, 32'd0));
        send_event(make_event(MODE_ACK, 1'b0, 32'd14, 32'd0, 32'd5));
        // Delay-triggered cut: low rtt, but sequence 15 is not above the highest seen
        set_reg(REG_ENABLE_DELAY_TRIGGER, 16'd1);
        set_reg(REG_DELAY_THRESHOLD_MS, 16'hFFFF);
        send_event(make_event(MODE_ACK, 1'b0, 32'd15, 32'd10, 32'd20));
    endtask

    // Hold the result side off for a long stretch while words keep coming, then pause
    task automatic test_output_stall();
        @(posedge aclk);
        stall_left = HOLDOFF_CYCLES;
        repeat (16) send_event(make_ack());
        wait_drained();
    endtask

    // One setting per phase; the eight phases cover every mix of enables
    task automatic test_random_traffic(input int phase);
        cwc_event_t ev;
        int         roll;
        case (phase)
            0: apply_setting(1'b1, 1'b0, 1'b0, 16'd20, 16'd450, 16'd20, 16'd50);
            1: apply_setting(1'b0, 1'b1, 1'b0, 16'($urandom_range(200, 0)),
                             16'($urandom_range(400, 20)), 16'd20, 16'd50);
            2: apply_setting(1'b0, 1'b0, 1'b1, 16'd20, 16'd450, 16'd20, 16'd50);
            3: apply_setting(1'b1, 1'b1, 1'b1, WIN_MAX, 16'hFFFF, 16'd1, 16'd0);
            4: apply_setting(1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
            5: apply_setting(1'b0, 1'b1, 1'b1, 16'($urandom), 16'($urandom),
                             16'($urandom_range(200, 1)), 16'($urandom));
            6: apply_setting(1'b1, 1'b1, 1'b0, 16'd100, 16'd100, 16'd5, 16'd30);
            default: apply_setting(1'b0, 1'b0, 1'b0, 16'($urandom), 16'($urandom),
                                   16'($urandom_range(50, 1)),
                                   16'($urandom_range(300, 0)));
        endcase
        // Start the stream near a wrap of time or sequence in some phases
        clock_ms = (phase == 3) ? 32'hFFFF_F000 : $urandom;
        next_seq = (phase == 5) ? 32'hFFFF_FF00 : $urandom_range(1000, 0);
        repeat (PHASE_ITEMS) begin
            roll = $urandom_range(99, 0);
            ev.mode = 1'($urandom_range(1, 0));
            ev.timeout_flag = 1'($urandom_range(1, 0));
            ev.seq = $urandom;
            ev.sent_ms = $urandom;
            ev.arrival_ms = $urandom;
            if (roll >= 8 && roll < 30) begin
                ev.mode = MODE_SENT;
                ev.timeout_flag = ($urandom_range(2, 0) == 0);
            end else if (roll >= 30) begin
                ev = make_ack();
            end
            send_event(ev);
        end
    endtask

    // Result side: random stalls, or a long hold-off when one is requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_tready = 1'b0;
                stall_left = stall_left - 1;
            end else begin
                m_tready = ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        window_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, window %0d timeout %0d",
                         $time, m_tdata[15:0], m_tdata[32:16]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_tdata[15:0] !== want.window) begin
                    $display("%0t: window expected %0d, got %0d",
                             $time, want.window, m_tdata[15:0]);
                    n_errors++;
                end
                if (m_tdata[32:16] !== want.timeout) begin
                    $display("%0t: timeout_value expected %0d, got %0d",
                             $time, want.timeout, m_tdata[32:16]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        // Prediction starts from the reset values
        en_aimd = 1'b0;
        en_dtrig = 1'b0;
        en_dbased = 1'b1;
        threshold_r = RST_DELAY_THRESHOLD;
        tick_r = RST_TICK_MS;
        exp_window = RST_INITIAL_WINDOW;
        exp_min_rtt = RST_INITIAL_MIN_RTT;
        exp_progress = '0;
        exp_top_seq = '0;
        exp_tick_start = '0;
        exp_tick_acks = '0;
        clock_ms = '0;
        next_seq = '0;
        tx_idle_pct = 36;
        rx_idle_pct = 45;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_special_cases();
        for (int ph = 0; ph < 3; ph++) begin
            test_random_traffic(ph);
        end
        test_output_stall();
        tx_idle_pct = 45;
        rx_idle_pct = 36;
        for (int ph = 3; ph < 6; ph++) begin
            test_random_traffic(ph);
        end
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int ph = 6; ph < 8; ph++) begin
            test_random_traffic(ph);
        end

        // Let any stray result show up before the verdict
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Checked %0d result words against %0d accepted event words", n_checked,
                 n_events);
        $display("Run covered all enable mixes, register extremes, ticks, saturation, stalls");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cwc_pkg.sv
hdl/congestion_window_controller_core.sv
hdl/cwc_checker.sv
tb/congestion_window_controller_core_tb.sv
